### design/s20sx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s20sx_pkg: shared types and constants for the Salsa20 stream XOR engine
// Payload structs, register indexes, the sigma words, the lane slot layouts
// used by the round datapath and a few small helper functions.
// ----------------------------------------------------------------------------
package s20sx_pkg;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] result_word;
      logic [3:0]  result_count;
      logic        result_last;
   } rsp_payload_type;

   typedef logic [15:0][31:0] state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       load;
      logic       step;
      logic [1:0] step_sel;
      logic       row_layout;
      logic       feed;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic pos_zero;
   } status_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_0_TO_7   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_8_TO_15  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_16_TO_23 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_24_TO_31 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONCE        = 3'd4;

   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

   localparam logic [1:0] LAST_STEP = 2'd3;

   // Slot 4*lane+pos holds this state word while a column round runs.
   localparam logic [3:0] COL_SLOT_WORD [16] = '{
      4'd0,  4'd4,  4'd8,  4'd12,
      4'd5,  4'd9,  4'd13, 4'd1,
      4'd10, 4'd14, 4'd2,  4'd6,
      4'd15, 4'd3,  4'd7,  4'd11
   };

   // The same for a row round.
   localparam logic [3:0] ROW_SLOT_WORD [16] = '{
      4'd0,  4'd1,  4'd2,  4'd3,
      4'd5,  4'd6,  4'd7,  4'd4,
      4'd10, 4'd11, 4'd8,  4'd9,
      4'd15, 4'd12, 4'd13, 4'd14
   };

   function automatic logic [3:0] slot_word(input logic row, input logic [3:0] slot);
      logic [3:0] w;
      w = row ? ROW_SLOT_WORD[slot] : COL_SLOT_WORD[slot];
      return w;
   endfunction

   // Inverse of slot_word; only ever called with constant arguments.
   function automatic logic [3:0] find_slot(input logic row, input logic [3:0] word);
      logic [3:0] r;
      r = '0;
      for (int j = 0; j < 16; j++) begin
         if (slot_word(row, 4'(j)) == word) begin
            r = 4'(j);
         end
      end
      return r;
   endfunction

   // Rotation for each of the four dependent steps of a quarter round.
   function automatic logic [31:0] rotl_step(input logic [31:0] v, input logic [1:0] sel);
      logic [31:0] r;
      unique case (sel)
         2'd0: r = {v[24:0], v[31:25]};
         2'd1: r = {v[22:0], v[31:23]};
         2'd2: r = {v[18:0], v[31:19]};
         2'd3: r = {v[13:0], v[31:14]};
      endcase
      return r;
   endfunction

   function automatic state_type init_words(
      input logic [63:0] k0,
      input logic [63:0] k1,
      input logic [63:0] k2,
      input logic [63:0] k3,
      input logic [63:0] nonce,
      input logic [63:0] counter
   );
      state_type s;
      s[0]  = SIGMA0;
      s[1]  = k0[31:0];
      s[2]  = k0[63:32];
      s[3]  = k1[31:0];
      s[4]  = k1[63:32];
      s[5]  = SIGMA1;
      s[6]  = nonce[31:0];
      s[7]  = nonce[63:32];
      s[8]  = counter[31:0];
      s[9]  = counter[63:32];
      s[10] = SIGMA2;
      s[11] = k2[31:0];
      s[12] = k2[63:32];
      s[13] = k3[31:0];
      s[14] = k3[63:32];
      s[15] = SIGMA3;
      return s;
   endfunction

endpackage

### design/s20sx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s20sx_ctrl: controller of the Salsa20 stream XOR engine
// Owns the channel handshakes, the round and step counters and the state
// machine that sequences block generation and result delivery.
// ----------------------------------------------------------------------------
module s20sx_ctrl #(
   parameter int ROUND_COUNT = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output s20sx_pkg::cmd_type   cmd,
   input  s20sx_pkg::status_type status
);

   localparam int ROUND_WIDTH = $clog2(ROUND_COUNT);
   localparam logic [ROUND_WIDTH-1:0] LAST_ROUND = ROUND_WIDTH'(ROUND_COUNT - 1);
   // Layout the state is left in after the final round.
   localparam logic FINAL_ROW = 1'(ROUND_COUNT % 2);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ROUND = 2'd1;
   localparam logic [1:0] S_FEED  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             step_ff, step_in;
   logic [ROUND_WIDTH-1:0] round_ff, round_in;
   logic                   in_full_ff, in_full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   out_free;

   assign accept   = req_valid & ~in_full_ff;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      round_in        = round_ff;
      cmd             = '0;
      cmd.capture     = accept;
      cmd.step_sel    = step_ff;
      cmd.row_layout  = round_ff[0];

      unique case (state_ff)
         S_IDLE: begin
            if (in_full_ff) begin
               if (status.pos_zero) begin
                  cmd.load = 1'b1;
                  step_in  = '0;
                  round_in = '0;
                  state_in = S_ROUND;
               end else if (out_free) begin
                  cmd.emit = 1'b1;
               end
            end
         end
         S_ROUND: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 2'd1;
            if (step_ff == s20sx_pkg::LAST_STEP) begin
               round_in = round_ff + 1'b1;
               if (round_ff == LAST_ROUND) begin
                  state_in = S_FEED;
               end
            end
         end
         S_FEED: begin
            cmd.feed       = 1'b1;
            cmd.row_layout = FINAL_ROW;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // The input holding register is never filled and drained in one cycle,
   // since a stall is raised as long as it is full.
   assign in_full_in   = accept | (in_full_ff & ~cmd.emit);
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         round_ff     <= '0;
         in_full_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         round_ff     <= round_in;
         in_full_ff   <= in_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = in_full_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/s20sx_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s20sx_dpath: datapath of the Salsa20 stream XOR engine
// Holds the key and nonce registers, the round state, the keystream block,
// the block counter and word position, and the input and output payloads.
// ----------------------------------------------------------------------------
module s20sx_dpath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  s20sx_pkg::cmd_type                       cmd,
   output s20sx_pkg::status_type                    status,
   input  s20sx_pkg::req_payload_type               req_payload,
   input  logic                                     csr_write_en,
   input  logic [s20sx_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [s20sx_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   output s20sx_pkg::rsp_payload_type               rsp_payload
);

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff;
   logic [63:0] counter_ff, counter_in;
   logic [2:0]  pos_ff, pos_in;

   s20sx_pkg::req_payload_type in_ff;
   s20sx_pkg::rsp_payload_type out_ff;

   s20sx_pkg::state_type slots_ff, slots_in;
   s20sx_pkg::state_type init;
   s20sx_pkg::state_type stepped;
   s20sx_pkg::state_type relay_col2row, relay_row2col;
   s20sx_pkg::state_type loaded;
   s20sx_pkg::state_type final_col, final_row, final_words;

   logic [7:0][63:0] ks_ff, ks_in;
   logic [63:0]      ks_word;
   logic [63:0]      mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff  <= '0;
         key1_ff  <= '0;
         key2_ff  <= '0;
         key3_ff  <= '0;
         nonce_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            s20sx_pkg::CSR_KEY_0_TO_7:   key0_ff  <= csr_write_data;
            s20sx_pkg::CSR_KEY_8_TO_15:  key1_ff  <= csr_write_data;
            s20sx_pkg::CSR_KEY_16_TO_23: key2_ff  <= csr_write_data;
            s20sx_pkg::CSR_KEY_24_TO_31: key3_ff  <= csr_write_data;
            s20sx_pkg::CSR_NONCE:        nonce_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign init = s20sx_pkg::init_words(key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff,
                                       counter_ff);

   // Each lane keeps its quarter round in slots (a, b, c, d). One step updates
   // slot 1 from slots 0 and 3 and then rotates the lane by one slot, so the
   // next step finds its operands in the same places; four steps restore it.
   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [31:0] sum;
      assign sum            = slots_ff[4*l] + slots_ff[4*l+3];
      assign stepped[4*l]   = slots_ff[4*l+1] ^ s20sx_pkg::rotl_step(sum, cmd.step_sel);
      assign stepped[4*l+1] = slots_ff[4*l+2];
      assign stepped[4*l+2] = slots_ff[4*l+3];
      assign stepped[4*l+3] = slots_ff[4*l];
   end

   // Fixed rewiring between the column and row layouts at the end of a round,
   // plus the load and the readout in state word order.
   for (genvar s = 0; s < 16; s++) begin : g_slot
      assign relay_col2row[s] =
         stepped[s20sx_pkg::find_slot(1'b0, s20sx_pkg::slot_word(1'b1, 4'(s)))];
      assign relay_row2col[s] =
         stepped[s20sx_pkg::find_slot(1'b1, s20sx_pkg::slot_word(1'b0, 4'(s)))];
      assign loaded[s]    = init[s20sx_pkg::slot_word(1'b0, 4'(s))];
      assign final_col[s] = slots_ff[s20sx_pkg::find_slot(1'b0, 4'(s))];
      assign final_row[s] = slots_ff[s20sx_pkg::find_slot(1'b1, 4'(s))];
   end

   assign final_words = cmd.row_layout ? final_row : final_col;

   always_comb begin
      slots_in = slots_ff;
      if (cmd.load) begin
         slots_in = loaded;
      end else if (cmd.step) begin
         if (cmd.step_sel == s20sx_pkg::LAST_STEP) begin
            slots_in = cmd.row_layout ? relay_row2col : relay_col2row;
         end else begin
            slots_in = stepped;
         end
      end
   end

   for (genvar i = 0; i < 8; i++) begin : g_feed
      assign ks_in[i] = {final_words[2*i+1] + init[2*i+1], final_words[2*i] + init[2*i]};
   end

   assign ks_word = ks_ff[pos_ff];

   // A byte count of eight or more keeps the whole word.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         mask[8*b +: 8] = ((in_ff.byte_count >= 4'd8) || (4'(b) < in_ff.byte_count))
                          ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      counter_in = counter_ff;
      pos_in     = pos_ff;
      if (cmd.feed) begin
         counter_in = counter_ff + 64'd1;
      end
      if (cmd.emit) begin
         if (in_ff.last_of_message) begin
            counter_in = '0;
            pos_in     = '0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         pos_ff     <= '0;
      end else begin
         counter_ff <= counter_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (cmd.feed) begin
         ks_ff <= ks_in;
      end
      if (cmd.capture) begin
         in_ff <= req_payload;
      end
      if (cmd.emit) begin
         out_ff.result_word  <= (in_ff.data_word ^ ks_word) & mask;
         out_ff.result_count <= in_ff.byte_count;
         out_ff.result_last  <= in_ff.last_of_message;
      end
   end

   assign status.pos_zero = (pos_ff == 3'd0);
   assign rsp_payload     = out_ff;

endmodule

### design/salsa20_stream_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salsa20_stream_xor: Salsa20 stream cipher XOR engine
// Encrypts or decrypts 8-byte message words with a Salsa20 keystream built
// from the key and nonce registers and a 64-bit block counter.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                                handshake
//   req_     in         data_word, byte_count, last_of_message  valid / stall
//   rsp_     out        result_word, result_count, result_last  valid / stall
//   csr_     in         64-bit key or nonce register            write enable
//
// A word that starts a keystream block waits while the state is loaded, the
// rounds run at one quarter-round step per cycle in four parallel lanes and
// the feed-forward fills the block. Every other word uses the stored block.
// The input holds one word and the output register one result, so a new word
// is taken while a finished result waits on rsp_stall.
// Reset clears the key and nonce registers, block counter and keystream position.
//
module salsa20_stream_xor #(
   parameter int ROUND_COUNT = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  s20sx_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output s20sx_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_write_en,
   input  logic [s20sx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [s20sx_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   s20sx_pkg::cmd_type    cmd;
   s20sx_pkg::status_type status;

   s20sx_ctrl #(
      .ROUND_COUNT(ROUND_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   s20sx_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_payload    (rsp_payload)
   );

endmodule
